// ===== sv/sbp_pkg.sv =====
package sbp_pkg;

  // Number of tone channels that the score may address.
  localparam int CHANNELS = 3;
  localparam logic [4:0] CHAN_LIMIT = 5'(CHANNELS);

  // High nibble of a command byte.
  localparam logic [3:0] OPC_OFF    = 4'h8;
  localparam logic [3:0] OPC_ON     = 4'h9;
  localparam logic [3:0] OPC_REWIND = 4'hE;
  localparam logic [3:0] OPC_STOP   = 4'hF;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ON     = 3'd1,
    EV_OFF    = 3'd2,
    EV_STOP   = 3'd3,
    EV_REWIND = 3'd4,
    EV_DELAY  = 3'd5
  } event_t;

  typedef enum logic [3:0] {
    MODE_CMD  = 4'b0001,
    MODE_DLO  = 4'b0010,
    MODE_NOTE = 4'b0100,
    MODE_WAIT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] score_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] channel;
    logic [6:0] note;
    logic       want_byte;
    logic       playing;
  } res_t;

endpackage

// ===== sv/sbp_if.sv =====
interface sbp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] score_byte;

  modport source (output valid, output operation, output score_byte, input ready);
  modport sink (input valid, input operation, input score_byte, output ready);
endinterface

interface sbp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] channel;
  logic [6:0] note;
  logic       want_byte;
  logic       playing;

  modport source (output valid, output event_res, output channel, output note,
                  output want_byte, output playing, input ready);
  modport sink (input valid, input event_res, input channel, input note,
                input want_byte, input playing, output ready);
endinterface

// ===== sv/sbp_in_stage.sv =====
module sbp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  sbp_in_if.sink        in_ch,
  input  logic          advance,
  output logic          s1_valid,
  output sbp_pkg::item_t s1_item
);
  import sbp_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The input register may take a new request whenever its content moves on.
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation  <= in_ch.operation;
      item_r.score_byte <= in_ch.score_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

// ===== sv/sbp_core.sv =====
module sbp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  sbp_pkg::item_t s1_item,
  output sbp_pkg::res_t  res
);
  import sbp_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [14:0] delay_r, delay_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        play_r, play_nxt;
  event_t      ev;
  logic [1:0]  ch;
  logic [6:0]  nt;
  logic [3:0]  opc;
  logic [3:0]  cmd_chan;
  logic [3:0]  held_chan;

  assign opc       = s1_item.score_byte[7:4];
  assign cmd_chan  = s1_item.score_byte[3:0];
  assign held_chan = held_r[3:0];

  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    delay_nxt = delay_r;
    tick_nxt  = tick_r;
    play_nxt  = play_r;
    ev        = EV_NONE;
    ch        = 2'd0;
    nt        = 7'd0;
    if (play_r) begin
      if (s1_item.operation) begin
        // Ticks only count while a delay is running.
        if (mode_r == MODE_WAIT) begin
          if (tick_r > {1'b0, delay_r}) begin
            tick_nxt = 16'd0;
            mode_nxt = MODE_CMD;
          end else begin
            tick_nxt = tick_r + 16'd1;
          end
        end
      end else begin
        unique case (mode_r)
          MODE_CMD: begin
            if (!s1_item.score_byte[7]) begin
              held_nxt = s1_item.score_byte;
              mode_nxt = MODE_DLO;
            end else begin
              unique case (opc)
                OPC_OFF: begin
                  if ({1'b0, cmd_chan} < CHAN_LIMIT) begin
                    ev = EV_OFF;
                    ch = cmd_chan[1:0];
                  end
                end
                OPC_ON: begin
                  held_nxt = s1_item.score_byte;
                  mode_nxt = MODE_NOTE;
                end
                OPC_STOP: begin
                  play_nxt = 1'b0;
                  ev       = EV_STOP;
                end
                OPC_REWIND: begin
                  delay_nxt = 15'd0;
                  tick_nxt  = 16'd0;
                  mode_nxt  = MODE_WAIT;
                  ev        = EV_REWIND;
                end
                default: begin
                  // Unknown opcodes are skipped.
                end
              endcase
            end
          end
          MODE_DLO: begin
            delay_nxt = {held_r[6:0], s1_item.score_byte};
            tick_nxt  = 16'd0;
            mode_nxt  = MODE_WAIT;
            ev        = EV_DELAY;
          end
          MODE_NOTE: begin
            if ({1'b0, held_chan} < CHAN_LIMIT) begin
              ev = EV_ON;
              ch = held_chan[1:0];
              nt = s1_item.score_byte[6:0];
            end
            mode_nxt = MODE_CMD;
          end
          MODE_WAIT: begin
            // Bytes that arrive during a delay are dropped.
          end
          default: begin
            mode_nxt = MODE_CMD;
          end
        endcase
      end
    end
  end

  assign res.event_res = ev;
  assign res.channel   = ch;
  assign res.note      = nt;
  assign res.want_byte = play_nxt && (mode_nxt != MODE_WAIT);
  assign res.playing   = play_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CMD;
      held_r  <= 8'd0;
      delay_r <= 15'd0;
      tick_r  <= 16'd0;
      play_r  <= 1'b1;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      delay_r <= delay_nxt;
      tick_r  <= tick_nxt;
      play_r  <= play_nxt;
    end
  end
endmodule

// ===== sv/sbp_out_stage.sv =====
module sbp_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  sbp_pkg::res_t res,
  output logic          advance,
  sbp_out_if.source     out_ch
);
  import sbp_pkg::*;

  logic valid_r;
  res_t res_r;

  // A new result may enter when the register is empty or is being drained.
  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.event_res = res_r.event_res;
  assign out_ch.channel   = res_r.channel;
  assign out_ch.note      = res_r.note;
  assign out_ch.want_byte = res_r.want_byte;
  assign out_ch.playing   = res_r.playing;
endmodule

// ===== sv/score_byte_player.sv =====
// A request is held in the input register, then its result in the output register.
// Throughput: one request per cycle unless out_ch.ready stalls the output; both
// registers pass on their content in the same cycle that they take a new one.
// Reset (rst_n low at a clock edge) empties both registers, returns the parser
// to expecting a command byte, clears the delay and tick count and sets playing.
module score_byte_player (
  input  logic      clk,
  input  logic      rst_n,
  sbp_in_if.sink    in_ch,
  sbp_out_if.source out_ch
);
  import sbp_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  advance;
  logic  fire;
  res_t  res;

  assign fire = s1_valid && advance;

  sbp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  sbp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .s1_item (s1_item),
    .res     (res)
  );

  sbp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

  a_want_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.want_byte && !out_ch.playing))
    else $error("want_byte reported while stopped");

  a_stop_clears_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.event_res == EV_STOP) |-> !out_ch.playing)
    else $error("stop event with playing still set");

  a_on_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.event_res == EV_ON || out_ch.event_res == EV_OFF))
      |-> ({3'b0, out_ch.channel} < CHAN_LIMIT))
    else $error("note event on a channel out of range");

  a_stopped_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.playing && out_ch.event_res != EV_STOP)
      |-> out_ch.event_res == EV_NONE)
    else $error("event reported after stop");
endmodule
